### sv/sfd_pkg.sv
package sfd_pkg;

  localparam int SFD_LENGTH_BITS = 31;

  localparam logic [1:0] KIND_CMD   = 2'd0;
  localparam logic [1:0] KIND_KEY   = 2'd1;
  localparam logic [1:0] KIND_VALUE = 2'd2;
  localparam logic [1:0] KIND_BODY  = 2'd3;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_HEADER  = 2'd1;
  localparam logic [1:0] ERR_LENGTH  = 2'd2;
  localparam logic [1:0] ERR_NO_NUL  = 2'd3;

  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef struct packed {
    logic [1:0] field_kind;
    logic       has_data;
    logic [7:0] data_out;
    logic       field_last;
    logic       frame_last;
    logic [1:0] error_code;
    logic       last;
  } result_t;

  typedef struct packed {
    result_t [2:0] res;
    logic [1:0]    n;
  } step_t;

endpackage

### sv/sfd_parser.sv
module sfd_parser
  import sfd_pkg::*;
#(
  parameter int LENGTH_BITS = SFD_LENGTH_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  output step_t      step
);

  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_CMD     = 4'd1;
  localparam logic [3:0] M_KEY     = 4'd2;
  localparam logic [3:0] M_VALUE   = 4'd3;
  localparam logic [3:0] M_BADLINE = 4'd4;
  localparam logic [3:0] M_BODYLEN = 4'd5;
  localparam logic [3:0] M_BODYNUL = 4'd6;
  localparam logic [3:0] M_ERR     = 4'd8;

  localparam int LF_FOUND  = 0;
  localparam int LF_ACTIVE = 1;
  localparam int LF_BAD    = 2;
  localparam int LF_DIGIT  = 3;

  localparam logic [3:0] NAME_LEN = 4'd14;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  typedef struct packed {
    logic [3:0]             mode;
    logic                   esc;
    logic                   crp;
    logic                   ls;
    logic [3:0]             nmi;
    logic                   nmm;
    logic [3:0]             lf;
    logic [LENGTH_BITS-1:0] lv;
    logic [LENGTH_BITS-1:0] br;
    result_t [2:0]          res;
    logic [1:0]             n;
  } work_t;

  work_t cur;
  work_t nxt;

  function automatic logic [7:0] name_char(input logic [3:0] i);
    logic [7:0] ch;
    case (i)
      4'd0:  ch = "c";
      4'd1:  ch = "o";
      4'd2:  ch = "n";
      4'd3:  ch = "t";
      4'd4:  ch = "e";
      4'd5:  ch = "n";
      4'd6:  ch = "t";
      4'd7:  ch = "-";
      4'd8:  ch = "l";
      4'd9:  ch = "e";
      4'd10: ch = "n";
      4'd11: ch = "g";
      4'd12: ch = "t";
      4'd13: ch = "h";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      "n":     r = CH_LF;
      "r":     r = CH_CR;
      "c":     r = CH_COLON;
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic work_t put(input work_t s, input logic [1:0] k, input logic h,
                                input logic [7:0] d, input logic fl, input logic frl,
                                input logic [1:0] e);
    work_t t;
    t = s;
    if (t.n != 2'd3) begin
      t.res[t.n] = '{field_kind: k, has_data: h, data_out: d, field_last: fl,
                     frame_last: frl, error_code: e, last: 1'b0};
      t.n = t.n + 2'd1;
    end
    return t;
  endfunction

  function automatic work_t fail(input work_t s, input logic [1:0] code);
    work_t t;
    t = s;
    t.mode = M_ERR | {2'b00, code};
    t = put(t, KIND_CMD, 1'b0, 8'h00, 1'b0, 1'b0, code);
    return t;
  endfunction

  function automatic work_t key_byte(input work_t s, input logic [7:0] c);
    work_t t;
    logic [7:0] lc;
    t = s;
    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    t = put(t, KIND_KEY, 1'b1, c, 1'b0, 1'b0, ERR_NONE);
    if (t.nmi < NAME_LEN && lc == name_char(t.nmi)) t.nmi = t.nmi + 4'd1;
    else t.nmm = 1'b1;
    return t;
  endfunction

  function automatic work_t value_byte(input work_t s, input logic [7:0] c);
    work_t t;
    logic [LENGTH_BITS+3:0] v;
    t = s;
    v = {1'b0, t.lv, 3'b000} + {3'b000, t.lv, 1'b0} + {{LENGTH_BITS{1'b0}}, c[3:0]};
    t = put(t, KIND_VALUE, 1'b1, c, 1'b0, 1'b0, ERR_NONE);
    if (t.lf[LF_ACTIVE]) begin
      if (c >= "0" && c <= "9") begin
        t.lf[LF_DIGIT] = 1'b1;
        if (v[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) begin
          t.lf[LF_BAD] = 1'b1;
          t.lv = LEN_MAX;
        end else begin
          t.lv = v[LENGTH_BITS-1:0];
        end
      end else begin
        t.lf[LF_BAD] = 1'b1;
      end
    end
    return t;
  endfunction

  function automatic work_t line_content(input work_t s, input logic [7:0] c);
    work_t t;
    t = s;
    if (t.mode == M_KEY) begin
      if (c == CH_COLON) begin
        if (!t.ls) begin
          t.mode = M_BADLINE;
        end else begin
          if (t.esc) begin
            t.esc = 1'b0;
            t = key_byte(t, CH_BSL);
          end
          t = put(t, KIND_KEY, 1'b0, 8'h00, 1'b1, 1'b0, ERR_NONE);
          if (t.nmi == NAME_LEN && !t.nmm && !t.lf[LF_FOUND]) begin
            t.lf[LF_FOUND]  = 1'b1;
            t.lf[LF_ACTIVE] = 1'b1;
          end
          t.nmi  = 4'd0;
          t.nmm  = 1'b0;
          t.mode = M_VALUE;
        end
      end else begin
        t.ls = 1'b1;
        if (t.esc) begin
          t.esc = 1'b0;
          t = key_byte(t, unescape(c));
        end else if (c == CH_BSL) begin
          t.esc = 1'b1;
        end else begin
          t = key_byte(t, c);
        end
      end
    end else begin
      if (t.esc) begin
        t.esc = 1'b0;
        t = value_byte(t, unescape(c));
      end else if (c == CH_BSL) begin
        t.esc = 1'b1;
      end else begin
        t = value_byte(t, c);
      end
    end
    return t;
  endfunction

  function automatic work_t line_end(input work_t s);
    work_t t;
    t = s;
    if (t.mode == M_KEY) begin
      if (t.ls) t = fail(t, ERR_HEADER);
      else if (t.lf[LF_BAD]) t = fail(t, ERR_LENGTH);
      else if (t.lf[LF_FOUND]) begin
        t.br   = t.lv;
        t.mode = M_BODYLEN;
      end else begin
        t.mode = M_BODYNUL;
      end
    end else begin
      if (t.esc) begin
        t.esc = 1'b0;
        t = value_byte(t, CH_BSL);
      end
      t = put(t, KIND_VALUE, 1'b0, 8'h00, 1'b1, 1'b0, ERR_NONE);
      if (t.lf[LF_ACTIVE]) begin
        if (!t.lf[LF_DIGIT]) t.lf[LF_BAD] = 1'b1;
        t.lf[LF_ACTIVE] = 1'b0;
      end
      t.mode = M_KEY;
      t.ls   = 1'b0;
    end
    return t;
  endfunction

  function automatic work_t frame_end(input work_t s);
    work_t t;
    t = put(s, KIND_BODY, 1'b0, 8'h00, 1'b1, 1'b1, ERR_NONE);
    t.mode = M_IDLE;
    t.esc  = 1'b0;
    t.crp  = 1'b0;
    t.ls   = 1'b0;
    t.nmi  = 4'd0;
    t.nmm  = 1'b0;
    t.lf   = 4'd0;
    t.lv   = '0;
    t.br   = '0;
    return t;
  endfunction

  always_comb begin
    work_t s;
    logic [7:0] b;
    s = cur;
    s.res = '0;
    s.n = 2'd0;
    b = data_byte;
    if (s.mode >= M_ERR) begin
      s = put(s, KIND_CMD, 1'b0, 8'h00, 1'b0, 1'b0, s.mode[1:0]);
    end else begin
      unique case (s.mode)
        M_IDLE: begin
          if (b != CH_LF && b != CH_CR) begin
            s.mode = M_CMD;
            s = put(s, KIND_CMD, 1'b1, b, 1'b0, 1'b0, ERR_NONE);
          end
        end
        M_CMD: begin
          if (s.crp) begin
            s.crp = 1'b0;
            if (b != CH_LF) s = put(s, KIND_CMD, 1'b1, CH_CR, 1'b0, 1'b0, ERR_NONE);
          end
          if (b == CH_CR) s.crp = 1'b1;
          else if (b == CH_LF) begin
            s = put(s, KIND_CMD, 1'b0, 8'h00, 1'b1, 1'b0, ERR_NONE);
            s.mode = M_KEY;
            s.ls = 1'b0;
          end else s = put(s, KIND_CMD, 1'b1, b, 1'b0, 1'b0, ERR_NONE);
        end
        M_KEY, M_VALUE: begin
          if (s.crp) begin
            s.crp = 1'b0;
            if (b != CH_LF) s = line_content(s, CH_CR);
          end
          if (s.mode == M_BADLINE) begin
            if (b == CH_LF) s = fail(s, ERR_HEADER);
          end else if (b == CH_CR) s.crp = 1'b1;
          else if (b == CH_LF) s = line_end(s);
          else s = line_content(s, b);
        end
        M_BADLINE: begin
          if (b == CH_LF) s = fail(s, ERR_HEADER);
        end
        M_BODYLEN: begin
          if (s.br != '0) begin
            s = put(s, KIND_BODY, 1'b1, b, 1'b0, 1'b0, ERR_NONE);
            s.br = s.br - 1'b1;
          end else if (b == CH_NUL) s = frame_end(s);
          else s = fail(s, ERR_NO_NUL);
        end
        M_BODYNUL: begin
          if (b == CH_NUL) s = frame_end(s);
          else s = put(s, KIND_BODY, 1'b1, b, 1'b0, 1'b0, ERR_NONE);
        end
        default: s = fail(s, ERR_HEADER);
      endcase
    end
    if (s.n != 2'd0) s.res[s.n - 2'd1].last = 1'b1;
    nxt = s;
  end

  assign step.res = nxt.res;
  assign step.n   = nxt.n;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
    end else if (accept) begin
      cur <= nxt;
    end
  end

endmodule

### sv/stomp_frame_deframer.sv
// STOMP frame deframer: one stream byte enters per item on the s_ side and
// turns into zero to two result items on the m_ side (command, header key,
// header value and body bytes plus end markers, or one error item per byte
// once an error has occurred; errors stay until reset). While m_tready is high, a
// byte that causes a single result is taken every cycle; a byte that causes more results
// holds the input until its last item is taken, as the result buffer drains one
// item per cycle. The parser state updates in the same cycle the byte is accepted.
module stomp_frame_deframer
  import sfd_pkg::*;
#(
  parameter int LENGTH_BITS = SFD_LENGTH_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // has_data, data_out, field_last, frame_last, error_code
  output logic [1:0]  m_tuser,  // field_kind
  output logic        m_tlast   // last
);

  step_t         step;
  result_t [2:0] res_q;
  logic [1:0]    ptr;
  logic [1:0]    rem;
  logic          s_accept;
  logic          m_accept;
  result_t       cur_res;

  assign s_tready = (rem == 2'd0) || (rem == 2'd1 && m_tready);
  assign s_accept = s_tvalid && s_tready;
  assign m_tvalid = rem != 2'd0;
  assign m_accept = m_tvalid && m_tready;

  sfd_parser #(.LENGTH_BITS(LENGTH_BITS)) u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (s_accept),
    .data_byte (s_tdata),
    .step      (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 2'd0;
      ptr <= 2'd0;
    end else if (s_accept) begin
      rem <= step.n;
      ptr <= 2'd0;
    end else if (m_accept) begin
      rem <= rem - 2'd1;
      ptr <= ptr + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) res_q <= step.res;
  end

  assign cur_res = res_q[ptr];
  assign m_tuser = cur_res.field_kind;
  assign m_tlast = cur_res.last;
  assign m_tdata = {3'b000, cur_res.error_code, cur_res.frame_last, cur_res.field_last,
                    cur_res.data_out, cur_res.has_data};

`ifndef SYNTH
  a_rem_range: assert property (@(posedge clk) disable iff (rst) rem != 2'd3)
    else $error("result count out of range");
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    s_accept && step.n != 2'd0 |=> m_tvalid)
    else $error("results lost after load");
  a_last_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && rem == 2'd1 |-> cur_res.last)
    else $error("final item of a byte without last");
  a_last_mid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && rem == 2'd2 |-> !cur_res.last)
    else $error("last set before final item");
`endif

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import sfd_pkg::*;

  localparam logic [3:0] PM_IDLE = 4'd0, PM_CMD = 4'd1, PM_KEY = 4'd2, PM_VALUE = 4'd3,
                         PM_BADLINE = 4'd4, PM_BODYLEN = 4'd5, PM_BODYNUL = 4'd6,
                         PM_ERR = 4'd8;
  localparam logic [31:0] LEN_MAX = 32'h7fff_ffff;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0] m_tuser;
  logic m_tlast;

  stomp_frame_deframer dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  logic [7:0] byte_q[$];
  result_t expected_q[$];
  int mismatches = 0;
  int bytes_sent = 0;
  int results_seen = 0;
  int frames_seen = 0;
  int errors_seen = 0;
  bit s_fire = 0;

  // parser state copy
  logic [3:0] pmode;
  bit esc_p, cr_p, line_st, name_bad;
  logic [3:0] name_idx;
  bit lf_found, lf_active, lf_bad, lf_digit;
  logic [31:0] len_val;
  logic [31:0] body_left;
  result_t step_res[$];

  string len_name = "content-length";

  function void clear_frame();
    pmode = PM_IDLE; esc_p = 0; cr_p = 0; line_st = 0; name_idx = 0; name_bad = 0;
    lf_found = 0; lf_active = 0; lf_bad = 0; lf_digit = 0; len_val = 0; body_left = 0;
  endfunction

  function void emit(logic [1:0] k, bit h, logic [7:0] d, bit fl, bit frl, logic [1:0] e);
    result_t r;
    r.field_kind = k; r.has_data = h; r.data_out = d; r.field_last = fl;
    r.frame_last = frl; r.error_code = e; r.last = 1'b0;
    step_res.push_back(r);
  endfunction

  function void raise_err(logic [1:0] code);
    pmode = PM_ERR + code;
    emit(KIND_CMD, 0, 0, 0, 0, code);
  endfunction

  function logic [7:0] unesc(logic [7:0] c);
    if (c == "n") return CH_LF;
    if (c == "r") return CH_CR;
    if (c == "c") return CH_COLON;
    return c;
  endfunction

  function void key_out(logic [7:0] c);
    logic [7:0] lc;
    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    emit(KIND_KEY, 1, c, 0, 0, ERR_NONE);
    if (name_idx < 14 && lc == len_name[name_idx]) name_idx++;
    else name_bad = 1;
  endfunction

  function void value_out(logic [7:0] c);
    logic [35:0] v;
    emit(KIND_VALUE, 1, c, 0, 0, ERR_NONE);
    if (!lf_active) return;
    if (c >= "0" && c <= "9") begin
      v = len_val * 36'd10 + (c - "0");
      lf_digit = 1;
      if (v > LEN_MAX) begin
        lf_bad = 1;
        v = LEN_MAX;
      end
      len_val = v[31:0];
    end else begin
      lf_bad = 1;
    end
  endfunction

  function void line_byte(logic [7:0] c);
    if (pmode == PM_KEY) begin
      if (c == CH_COLON) begin
        if (!line_st) begin
          pmode = PM_BADLINE;
          return;
        end
        if (esc_p) begin
          esc_p = 0;
          key_out(CH_BSL);
        end
        emit(KIND_KEY, 0, 0, 1, 0, ERR_NONE);
        if (name_idx == 14 && !name_bad && !lf_found) begin
          lf_found = 1;
          lf_active = 1;
        end
        name_idx = 0; name_bad = 0; pmode = PM_VALUE;
        return;
      end
      line_st = 1;
      if (esc_p) begin
        esc_p = 0;
        key_out(unesc(c));
      end else if (c == CH_BSL) esc_p = 1;
      else key_out(c);
    end else begin
      if (esc_p) begin
        esc_p = 0;
        value_out(unesc(c));
      end else if (c == CH_BSL) esc_p = 1;
      else value_out(c);
    end
  endfunction

  function void line_done();
    if (pmode == PM_KEY) begin
      if (line_st) begin
        raise_err(ERR_HEADER);
        return;
      end
      if (lf_bad) begin
        raise_err(ERR_LENGTH);
        return;
      end
      if (lf_found) begin
        body_left = len_val & LEN_MAX;
        pmode = PM_BODYLEN;
      end else pmode = PM_BODYNUL;
      return;
    end
    if (esc_p) begin
      esc_p = 0;
      value_out(CH_BSL);
    end
    emit(KIND_VALUE, 0, 0, 1, 0, ERR_NONE);
    if (lf_active) begin
      if (!lf_digit) lf_bad = 1;
      lf_active = 0;
    end
    pmode = PM_KEY;
    line_st = 0;
  endfunction

  function void frame_done();
    emit(KIND_BODY, 0, 0, 1, 1, ERR_NONE);
    clear_frame();
  endfunction

  function void predict_byte(logic [7:0] b);
    step_res.delete();
    if (pmode >= PM_ERR) begin
      emit(KIND_CMD, 0, 0, 0, 0, 2'(pmode - PM_ERR));
    end else if (pmode == PM_IDLE) begin
      if (b != CH_LF && b != CH_CR) begin
        pmode = PM_CMD;
        emit(KIND_CMD, 1, b, 0, 0, ERR_NONE);
      end
    end else if (pmode == PM_CMD) begin
      if (cr_p) begin
        cr_p = 0;
        if (b != CH_LF) emit(KIND_CMD, 1, CH_CR, 0, 0, ERR_NONE);
      end
      if (b == CH_CR) cr_p = 1;
      else if (b == CH_LF) begin
        emit(KIND_CMD, 0, 0, 1, 0, ERR_NONE);
        pmode = PM_KEY;
        line_st = 0;
      end else emit(KIND_CMD, 1, b, 0, 0, ERR_NONE);
    end else if (pmode == PM_KEY || pmode == PM_VALUE) begin
      if (cr_p) begin
        cr_p = 0;
        if (b != CH_LF) line_byte(CH_CR);
      end
      if (pmode == PM_BADLINE) begin
        if (b == CH_LF) raise_err(ERR_HEADER);
      end else if (b == CH_CR) cr_p = 1;
      else if (b == CH_LF) line_done();
      else line_byte(b);
    end else if (pmode == PM_BADLINE) begin
      if (b == CH_LF) raise_err(ERR_HEADER);
    end else if (pmode == PM_BODYLEN) begin
      if (body_left != 0) begin
        emit(KIND_BODY, 1, b, 0, 0, ERR_NONE);
        body_left--;
      end else if (b == CH_NUL) frame_done();
      else raise_err(ERR_NO_NUL);
    end else if (pmode == PM_BODYNUL) begin
      if (b == CH_NUL) frame_done();
      else emit(KIND_BODY, 1, b, 0, 0, ERR_NONE);
    end else begin
      raise_err(ERR_HEADER);
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) expected_q.push_back(step_res[i]);
  endfunction

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // stimulus helpers
  function logic [7:0] text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return CH_BSL;
    if (r < 8) return CH_CR;
    if (r < 10) return 8'($urandom_range(0, 255));
    return ($urandom_range(8'h20, 8'h7e) == CH_COLON) ? "x" : 8'($urandom_range(8'h41, 8'h7a));
  endfunction

  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
  endtask

  task automatic push_frame();
    int nh, blen, r;
    bit counted;
    string key;
    if ($urandom_range(0, 3) == 0) push_str("\r\n");
    byte_q.push_back(8'($urandom_range(8'h41, 8'h5a)));
    for (int i = $urandom_range(0, 5); i > 0; i--) byte_q.push_back(text_byte());
    push_str($urandom_range(0, 1) ? "\n" : "\r\n");
    counted = ($urandom_range(0, 1) != 0);
    blen = $urandom_range(0, 8);
    nh = $urandom_range(0, 3);
    for (int h = 0; h < nh; h++) begin
      key = "";
      for (int i = $urandom_range(1, 5); i > 0; i--) key = {key, string'(text_byte())};
      push_str(key);
      byte_q.push_back(CH_COLON);
      for (int i = $urandom_range(0, 5); i > 0; i--) byte_q.push_back(text_byte());
      push_str("\n");
    end
    if (counted) begin
      r = $urandom_range(0, 2);
      push_str(r == 0 ? "content-length:" : (r == 1 ? "Content-Length:" : "CONTENT-length:"));
      push_str($sformatf("%0d", blen));
      push_str("\n");
    end
    push_str("\n");
    for (int i = 0; i < blen; i++)
      byte_q.push_back(counted ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 255)));
    byte_q.push_back(CH_NUL);
  endtask

  // driver
  int s_gap = 0;
  int m_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (s_fire) bytes_sent++;
      if (!s_tvalid || s_fire) begin
        if (s_gap > 0 || byte_q.size() == 0) begin
          if (s_gap > 0) s_gap--;
          s_tvalid <= 1'b0;
        end else begin
          s_tdata <= byte_q.pop_front();
          s_tvalid <= 1'b1;
          s_gap = gap_len();
        end
      end
      if (m_gap > 0) begin
        m_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        m_gap = gap_len();
      end
    end
  end

  // input and result monitors
  always @(posedge clk) begin
    result_t got, exp_r;
    s_fire = !rst && s_tvalid && s_tready;
    if (s_fire) predict_byte(s_tdata);
    if (!rst && m_tvalid && m_tready) begin
      got.field_kind = m_tuser;
      {got.error_code, got.frame_last, got.field_last, got.data_out, got.has_data} =
        m_tdata[12:0];
      got.last = m_tlast;
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item %p", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got.frame_last) frames_seen++;
        if (got.error_code != ERR_NONE) errors_seen++;
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", exp_r, got);
        end
      end
    end
  end

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic run_phase();
    wait (byte_q.size() == 0);
    @(posedge clk);
    while (s_tvalid || expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    clear_frame();
    // directed: heartbeats, escapes, lone CR, trailing backslash, counted body
    push_str("\r\n\nSEND\r\nk\\n\\r\\c\\\\\\q:v\\\r\nx:a\rb\\\n");
    push_str("content-length:3\ncontent-length:zz\n\n");
    byte_q.push_back(8'hff); byte_q.push_back(CH_NUL); byte_q.push_back(8'h0a);
    byte_q.push_back(CH_NUL);
    push_str("M\n\nab\0");
    byte_q.push_back(CH_NUL);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    run_phase();
    for (int i = 0; i < 8; i++) push_frame();
    run_phase();
    while (bytes_sent < 450) begin
      push_frame();
      if ($urandom_range(0, 30) == 0) begin
        // broken tail: pick one error path and stay in error for the rest of the run
        case ($urandom_range(0, 3))
          0: push_str("A\n:bad\n");
          1: push_str("A\nnocolon\n");
          2: push_str("A\ncontent-length:9x\n\n");
          default: push_str("A\ncontent-length:1\n\nzz");
        endcase
        for (int i = 0; i < 5; i++) byte_q.push_back(8'($urandom_range(0, 255)));
      end
      run_phase();
    end
    $display("%0d bytes in, %0d items out, %0d frames, %0d error items",
             bytes_sent, results_seen, frames_seen, errors_seen);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### stomp_frame_deframer.f
sv/sfd_pkg.sv
sv/sfd_parser.sv
sv/stomp_frame_deframer.sv
sim/tb_top.sv
